[hw/rtl/clock_page_replacement_translator_unit_macros.svh]
// Assertion macros for the translator RTL
`ifndef CLOCK_PAGE_REPLACEMENT_TRANSLATOR_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_TRANSLATOR_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define CPRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a property on the following clock edge
`define CPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cprt_pkg.sv]
// Shared constants, types and helpers of the page replacement translator
package cprt_pkg;

  localparam int unsigned MaxFrames = 64;
  localparam int unsigned FrameW    = $clog2(MaxFrames);
  localparam int unsigned CountW    = FrameW + 1;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PbW       = 5;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [PbW-1:0]    PageBitsReset = PbW'(12);
  localparam logic [CountW-1:0] FramesReset   = CountW'(MaxFrames);
  localparam logic [CntW-1:0]   CntMax        = '1;

  typedef logic [FrameW-1:0]    frame_idx_t;
  typedef logic [MaxFrames-1:0] frame_vec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_SWEEP
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_BITS     = 8'd0,
    CFG_FRAMES_IN_USE = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic capture;
    logic resolve;
    logic sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic hit_any;
    logic free_any;
    logic hand_used;
  } dp_status_t;

  function automatic frame_idx_t lowest_set(frame_vec_t v);
    frame_idx_t idx;
    idx = '0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = FrameW'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hw/rtl/cprt_ctrl.sv]
// Sequencer of the page replacement translator
`include "clock_page_replacement_translator_unit_macros.svh"

module cprt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cprt_pkg::dp_status_t status_i,
  output cprt_pkg::dp_cmd_t    cmd_o
);

  cprt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cprt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      cprt_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = cprt_pkg::S_MATCH;
        end
      end
      cprt_pkg::S_MATCH: begin
        cmd_o.capture = 1'b1;
        state_d       = cprt_pkg::S_DECIDE;
      end
      cprt_pkg::S_DECIDE: begin
        cmd_o.resolve = 1'b1;
        if (status_i.hit_any || status_i.free_any) begin
          state_d = cprt_pkg::S_IDLE;
        end else begin
          state_d = cprt_pkg::S_SWEEP;
        end
      end
      cprt_pkg::S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (!status_i.hand_used) begin
          state_d = cprt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cprt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != cprt_pkg::S_IDLE);

  `CPRT_ASSERT_NEXT(a_accept_to_match, start && !busy, state_q == cprt_pkg::S_MATCH,
                    "accepted beat did not enter match")
  `CPRT_ASSERT_NEXT(a_match_to_decide, state_q == cprt_pkg::S_MATCH,
                    state_q == cprt_pkg::S_DECIDE, "match did not advance to decide")
  `CPRT_ASSERT_NEXT(a_resolved_to_idle,
                    state_q == cprt_pkg::S_DECIDE && (status_i.hit_any || status_i.free_any),
                    state_q == cprt_pkg::S_IDLE, "resolved lookup did not release")
  `CPRT_ASSERT(a_one_cmd, $onehot0(cmd_o), "more than one datapath command")

endmodule

[hw/rtl/cprt_dp.sv]
// Datapath of the page replacement translator: frame table, clock hand, counters
module cprt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [cprt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cprt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [cprt_pkg::AddrW-1:0]      virtual_address_i,
  input  cprt_pkg::dp_cmd_t               cmd_i,
  output cprt_pkg::dp_status_t            status_o,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [cprt_pkg::FrameW-1:0]     frame_index_o,
  output logic [cprt_pkg::AddrW-1:0]      physical_address_o,
  output logic [cprt_pkg::AddrW-1:0]      page_number_o,
  output logic [cprt_pkg::CntW-1:0]       reference_count_o,
  output logic [cprt_pkg::CntW-1:0]       fault_count_o
);

  logic [cprt_pkg::PbW-1:0]    page_bits_q;
  logic [cprt_pkg::CountW-1:0] frames_q;
  logic [cprt_pkg::CountW-1:0] n_eff;

  logic [cprt_pkg::AddrW-1:0]  page_q;
  logic [cprt_pkg::AddrW-1:0]  offset_q;
  logic [cprt_pkg::AddrW-1:0]  frame_page_q [cprt_pkg::MaxFrames];
  cprt_pkg::frame_vec_t        valid_q, use_q, match_q, free_q, in_range;
  cprt_pkg::frame_idx_t        hand_q, cur_hand, next_hand, sel_idx;

  logic [cprt_pkg::CntW-1:0]   ref_q, ref_d, fault_q, fault_d;
  logic                        hit_any, free_any, hand_used, emit, fill, is_hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bits_q <= cprt_pkg::PageBitsReset;
      frames_q    <= cprt_pkg::FramesReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cprt_pkg::CFG_PAGE_BITS) begin
        page_bits_q <= cfg_data_i[cprt_pkg::PbW-1:0];
      end else if (cfg_index_i == cprt_pkg::CFG_FRAMES_IN_USE) begin
        frames_q <= cfg_data_i[cprt_pkg::CountW-1:0];
      end
    end
  end

  always_comb begin
    if (frames_q == '0) begin
      n_eff = cprt_pkg::CountW'(1);
    end else if (frames_q > cprt_pkg::CountW'(cprt_pkg::MaxFrames)) begin
      n_eff = cprt_pkg::CountW'(cprt_pkg::MaxFrames);
    end else begin
      n_eff = frames_q;
    end
  end

  always_comb begin
    for (int i = 0; i < cprt_pkg::MaxFrames; i++) begin
      in_range[i] = (cprt_pkg::CountW'(i) < n_eff);
    end
  end

  // split the address
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q   <= virtual_address_i >> page_bits_q;
      offset_q <= virtual_address_i & ~({cprt_pkg::AddrW{1'b1}} << page_bits_q);
    end
  end

  // parallel tag compare and empty-frame scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < cprt_pkg::MaxFrames; i++) begin
        match_q[i] <= valid_q[i] && in_range[i] && (frame_page_q[i] == page_q);
        free_q[i]  <= !valid_q[i] && in_range[i];
      end
    end
  end

  assign hit_any  = |match_q;
  assign free_any = |free_q;

  always_comb begin
    if ({1'b0, hand_q} >= n_eff) begin
      cur_hand = '0;
    end else begin
      cur_hand = hand_q;
    end
    if (({1'b0, cur_hand} + cprt_pkg::CountW'(1)) == n_eff) begin
      next_hand = '0;
    end else begin
      next_hand = cur_hand + cprt_pkg::FrameW'(1);
    end
  end

  assign hand_used = use_q[cur_hand];

  always_comb begin
    is_hit = cmd_i.resolve && hit_any;
    emit   = (cmd_i.resolve && (hit_any || free_any)) || (cmd_i.sweep && !hand_used);
    fill   = (cmd_i.resolve && !hit_any && free_any) || (cmd_i.sweep && !hand_used);
    if (cmd_i.resolve) begin
      sel_idx = hit_any ? cprt_pkg::lowest_set(match_q) : cprt_pkg::lowest_set(free_q);
    end else begin
      sel_idx = cur_hand;
    end
    ref_d   = (ref_q == cprt_pkg::CntMax) ? ref_q : ref_q + cprt_pkg::CntW'(1);
    fault_d = fault_q;
    if (!is_hit && fault_q != cprt_pkg::CntMax) begin
      fault_d = fault_q + cprt_pkg::CntW'(1);
    end
  end

  // frame table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      use_q   <= '0;
      hand_q  <= '0;
      ref_q   <= '0;
      fault_q <= '0;
    end else begin
      if (fill) begin
        valid_q[sel_idx] <= 1'b1;
      end
      if (emit) begin
        use_q[sel_idx] <= 1'b1;
        ref_q          <= ref_d;
        fault_q        <= fault_d;
      end else if (cmd_i.sweep) begin
        use_q[cur_hand] <= 1'b0;
      end
      if (cmd_i.sweep) begin
        hand_q <= next_hand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      frame_page_q[sel_idx] <= page_q;
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      hit_o              <= is_hit;
      frame_index_o      <= sel_idx;
      physical_address_o <= (cprt_pkg::AddrW'(sel_idx) << page_bits_q) | offset_q;
      page_number_o      <= page_q;
      reference_count_o  <= ref_d;
      fault_count_o      <= fault_d;
    end
  end

  assign status_o.hit_any   = hit_any;
  assign status_o.free_any  = free_any;
  assign status_o.hand_used = hand_used;

endmodule

[hw/rtl/clock_page_replacement_translator_unit.sv]
// Top level of the clock (second chance) page replacement translator
// An address is taken when start is high and busy is low. A hit or a fill of an empty frame
// goes through address split, parallel tag compare and resolve, and the result shows on the
// cycle after, marked by result_valid_o for that one cycle only: the receiver cannot stall,
// so take the beat when it appears. A start may be taken in that same result cycle. When all
// managed frames are full, the clock hand sweeps one frame per cycle over the managed
// frames (frames_in_use held to 1..64), clearing use bits until it finds a clear one.
// cfg_ready_o is always high; write configuration only while the unit is idle. The frame
// table comes out of reset empty, with no clearing pass.
module clock_page_replacement_translator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cprt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cprt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [cprt_pkg::AddrW-1:0]      virtual_address_i,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic [cprt_pkg::FrameW-1:0]     frame_index_o,
  output logic [cprt_pkg::AddrW-1:0]      physical_address_o,
  output logic [cprt_pkg::AddrW-1:0]      page_number_o,
  output logic [cprt_pkg::CntW-1:0]       reference_count_o,
  output logic [cprt_pkg::CntW-1:0]       fault_count_o
);

  cprt_pkg::dp_cmd_t    cmd;
  cprt_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  cprt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cprt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .virtual_address_i  (virtual_address_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .result_valid_o     (result_valid_o),
    .hit_o              (hit_o),
    .frame_index_o      (frame_index_o),
    .physical_address_o (physical_address_o),
    .page_number_o      (page_number_o),
    .reference_count_o  (reference_count_o),
    .fault_count_o      (fault_count_o)
  );

endmodule
